// ===== rtl/match_peak_frame_clustering_macros.svh =====
`ifndef MATCH_PEAK_FRAME_CLUSTERING_MACROS_SVH
`define MATCH_PEAK_FRAME_CLUSTERING_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MPFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpfc assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MPFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpfc assertion failed");

`endif

// ===== rtl/mpfc_pkg.sv =====
`default_nettype none

package mpfc_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int IMAGE_DIM  = 1024;

    localparam int IDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int COORD_W    = $clog2(IMAGE_DIM);
    localparam int BOUND_W    = $clog2(2 * IMAGE_DIM);
    localparam int SIZE_W     = 11;
    localparam int SCORE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int BOUND_MAX  = 2 * IMAGE_DIM - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

    localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 16'sd22282;
    localparam logic [SIZE_W-1:0]         WIDTH_RESET     = 11'd32;
    localparam logic [SIZE_W-1:0]         HEIGHT_RESET    = 11'd32;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_READ   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        ACT_BELOW    = 3'd0,
        ACT_NEW      = 3'd1,
        ACT_IMPROVED = 3'd2,
        ACT_KEPT     = 3'd3,
        ACT_FULL     = 3'd4,
        ACT_CLEARED  = 3'd5,
        ACT_READ     = 3'd6
    } t_action;

    typedef struct packed {
        t_req_type                  req_type;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic signed [SCORE_W-1:0]  score;
        logic [IDX_W-1:0]           entry_index;
    } t_request;

    typedef struct packed {
        t_action                    action;
        logic [IDX_W-1:0]           frame_index;
        logic [CNT_W-1:0]           frame_count;
        logic [COORD_W-1:0]         box_left;
        logic [COORD_W-1:0]         box_top;
        logic [BOUND_W-1:0]         box_right;
        logic [BOUND_W-1:0]         box_bottom;
        logic signed [SCORE_W-1:0]  box_score;
    } t_result;

    typedef struct packed {
        t_req_type                  req_type;
        logic                       above;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic signed [SCORE_W-1:0]  score;
        logic [BOUND_W-1:0]         right;
        logic [BOUND_W-1:0]         bottom;
        logic [IDX_W-1:0]           entry_index;
        logic [CNT_W-1:0]           count;
        logic [SIZE_W-1:0]          box_width;
        logic [SIZE_W-1:0]          box_height;
    } t_cmd;

    typedef struct packed {
        logic                       turn;
        logic                       claimed;
        t_action                    action;
        logic [IDX_W-1:0]           frame_index;
        logic [COORD_W-1:0]         left;
        logic [COORD_W-1:0]         top;
        logic [BOUND_W-1:0]         right;
        logic [BOUND_W-1:0]         bottom;
        logic signed [SCORE_W-1:0]  score;
    } t_token;

endpackage

`default_nettype wire

// ===== rtl/mpfc_cell.sv =====
`default_nettype none

module mpfc_cell (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [mpfc_pkg::IDX_W-1:0] i_cell_index,
    input  wire mpfc_pkg::t_cmd            i_cmd,
    input  wire mpfc_pkg::t_token          i_tok,
    output      mpfc_pkg::t_token          o_tok
);
    import mpfc_pkg::*;

    logic [COORD_W-1:0]        r_left;
    logic [COORD_W-1:0]        r_top;
    logic [BOUND_W-1:0]        r_right;
    logic [BOUND_W-1:0]        r_bottom;
    logic signed [SCORE_W-1:0] r_score;
    t_token                    r_tok;
    t_token                    n_tok;

    logic               live;
    logic               at_end;
    logic               near;
    logic               write;
    logic [COORD_W-1:0] diff_x;
    logic [COORD_W-1:0] diff_y;

    always_comb begin
        live   = {1'b0, i_cell_index} < i_cmd.count;
        at_end = {1'b0, i_cell_index} == i_cmd.count;
        diff_x = (r_left >= i_cmd.col) ? r_left - i_cmd.col : i_cmd.col - r_left;
        diff_y = (r_top >= i_cmd.row) ? r_top - i_cmd.row : i_cmd.row - r_top;
        near   = ({1'b0, diff_x} < i_cmd.box_width) && ({1'b0, diff_y} < i_cmd.box_height);
    end

    always_comb begin
        n_tok = i_tok;
        write = 1'b0;
        if (i_tok.turn) begin
            case (i_cmd.req_type)
                REQ_SAMPLE: begin
                    if (i_cmd.above && !i_tok.claimed) begin
                        if (live && near) begin
                            n_tok.claimed     = 1'b1;
                            n_tok.frame_index = i_cell_index;
                            if (i_cmd.score > r_score) begin
                                write        = 1'b1;
                                n_tok.action = ACT_IMPROVED;
                            end else begin
                                n_tok.action = ACT_KEPT;
                            end
                        end else if (at_end) begin
                            write             = 1'b1;
                            n_tok.claimed     = 1'b1;
                            n_tok.frame_index = i_cell_index;
                            n_tok.action      = ACT_NEW;
                        end
                    end
                end
                REQ_READ: begin
                    if (live && (i_cell_index == i_cmd.entry_index)) begin
                        n_tok.left   = r_left;
                        n_tok.top    = r_top;
                        n_tok.right  = r_right;
                        n_tok.bottom = r_bottom;
                        n_tok.score  = r_score;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write) begin
            r_left   <= i_cmd.col;
            r_top    <= i_cmd.row;
            r_right  <= i_cmd.right;
            r_bottom <= i_cmd.bottom;
            r_score  <= i_cmd.score;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== rtl/match_peak_frame_clustering.sv =====
// Groups correlation scores above a threshold into a table of up to 64 detection boxes.
// Input channel: i_in_valid / o_in_ready carry a request (score sample, clear, or read
// of one table entry). Output channel: o_out_valid / i_out_ready carry one result per
// request. Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data; the user
// must write it only while the block is idle, and the block itself does not enforce it.
// Each table entry lives in one cell of a 64-cell chain. An accepted transaction sends a
// token down the chain, one cell per cycle, so the first matching box in table order is
// the one that claims the sample. From the last cell the result passes through a pending
// register into the output register, and the input becomes ready again once the result
// moves into the output register, so the block takes no new transaction until it is done.
// When the receiver stalls, a finished result waits in a pending register behind the
// output register and the input stays not ready until it moves on; nothing is lost.
// Reset is synchronous and active low: it empties the table, returns the threshold and
// box size to their defaults and drops any transaction in flight. Box contents are not
// cleared; entries beyond the box count are never read.
`default_nettype none

`include "match_peak_frame_clustering_macros.svh"

module match_peak_frame_clustering (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire mpfc_pkg::t_request             i_in_data,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      mpfc_pkg::t_result              o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [mpfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mpfc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mpfc_pkg::*;

    logic signed [SCORE_W-1:0] r_threshold;
    logic [SIZE_W-1:0]         r_width;
    logic [SIZE_W-1:0]         r_height;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_busy;
    logic                      r_pend_valid;
    logic                      r_out_valid;
    t_result                   r_pend;
    t_result                   r_out;
    t_cmd                      r_cmd;
    t_token                    r_inject;
    t_token                    n_inject;

    t_token                    w_tok [0:MAX_FRAMES];
    logic [MAX_FRAMES:0]       w_turns;
    t_token                    tail;

    logic                      accept;
    logic                      move;
    logic                      above;
    logic [BOUND_W:0]          sum_x;
    logic [BOUND_W:0]          sum_y;
    logic [BOUND_W-1:0]        bound_x;
    logic [BOUND_W-1:0]        bound_y;

    assign o_in_ready  = !r_busy;
    assign accept      = i_in_valid && !r_busy;
    assign move        = r_pend_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign tail        = w_tok[MAX_FRAMES];

    always_comb begin
        above   = i_in_data.score > r_threshold;
        sum_x   = {2'b00, i_in_data.col} + {1'b0, r_width};
        sum_y   = {2'b00, i_in_data.row} + {1'b0, r_height};
        bound_x = (sum_x > (BOUND_W + 1)'(BOUND_MAX)) ? BOUND_W'(BOUND_MAX) : sum_x[BOUND_W-1:0];
        bound_y = (sum_y > (BOUND_W + 1)'(BOUND_MAX)) ? BOUND_W'(BOUND_MAX) : sum_y[BOUND_W-1:0];
    end

    always_comb begin
        n_inject             = '0;
        n_inject.turn        = 1'b1;
        n_inject.frame_index = '0;
        case (i_in_data.req_type)
            REQ_SAMPLE: n_inject.action = above ? ACT_FULL : ACT_BELOW;
            REQ_CLEAR:  n_inject.action = ACT_CLEARED;
            REQ_READ: begin
                n_inject.action      = ACT_READ;
                n_inject.frame_index = i_in_data.entry_index;
            end
            default:    n_inject.action = ACT_BELOW;
        endcase
    end

    always_comb begin
        case (r_cmd.req_type)
            REQ_CLEAR:  n_count = '0;
            REQ_SAMPLE: n_count = (tail.action == ACT_NEW) ? r_count + CNT_W'(1) : r_count;
            default:    n_count = r_count;
        endcase
    end

    assign w_tok[0] = r_inject;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        mpfc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cell_index (IDX_W'(g)),
            .i_cmd        (r_cmd),
            .i_tok        (w_tok[g]),
            .o_tok        (w_tok[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k <= MAX_FRAMES; k++) begin
            w_turns[k] = w_tok[k].turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THRESHOLD_RESET;
            r_width      <= WIDTH_RESET;
            r_height     <= HEIGHT_RESET;
            r_count      <= '0;
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_inject     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data;
                    CFG_WIDTH:     r_width     <= i_cfg_data[SIZE_W-1:0];
                    CFG_HEIGHT:    r_height    <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_inject <= accept ? n_inject : '0;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (tail.turn) begin
                r_count      <= n_count;
                r_pend_valid <= 1'b1;
            end else if (move) begin
                r_pend_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.req_type    <= i_in_data.req_type;
            r_cmd.above       <= above;
            r_cmd.col         <= i_in_data.col;
            r_cmd.row         <= i_in_data.row;
            r_cmd.score       <= i_in_data.score;
            r_cmd.right       <= bound_x;
            r_cmd.bottom      <= bound_y;
            r_cmd.entry_index <= i_in_data.entry_index;
            r_cmd.count       <= r_count;
            r_cmd.box_width   <= r_width;
            r_cmd.box_height  <= r_height;
        end
        if (tail.turn) begin
            r_pend.action      <= tail.action;
            r_pend.frame_index <= tail.frame_index;
            r_pend.frame_count <= n_count;
            r_pend.box_left    <= tail.left;
            r_pend.box_top     <= tail.top;
            r_pend.box_right   <= tail.right;
            r_pend.box_bottom  <= tail.bottom;
            r_pend.box_score   <= tail.score;
        end
        if (move) begin
            r_out <= r_pend;
        end
    end

    `MPFC_ASSERT_SAME(a_count_limit, 1'b1, r_count <= CNT_W'(MAX_FRAMES))
    `MPFC_ASSERT_SAME(a_single_token, 1'b1, $onehot0(w_turns))
    `MPFC_ASSERT_SAME(a_token_busy, (|w_turns) || r_pend_valid, r_busy)
    `MPFC_ASSERT_NEXT(a_new_counts, tail.turn && (tail.action == ACT_NEW), r_count == $past(r_count) + CNT_W'(1))

endmodule

`default_nettype wire
